[rtl/core/rgb_led_effect_engine_unit_assert.svh]
// ----------------------------------------------------------------------------
// rgb_led_effect_engine_unit_assert.svh
// Assertion macros used by the effect engine back end (rlee_back).
// ----------------------------------------------------------------------------
`ifndef RGB_LED_EFFECT_ENGINE_UNIT_ASSERT_SVH
`define RGB_LED_EFFECT_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define RLEE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RLEE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/rlee_pkg.sv]
// ----------------------------------------------------------------------------
// rlee_pkg
// Types, constants and color helpers for the RGB LED effect engine.
// ----------------------------------------------------------------------------
package rlee_pkg;

    localparam int NUM_LEDS         = 6;
    localparam int LED_IDX_W        = $clog2(NUM_LEDS);
    localparam int LAST_LED         = NUM_LEDS - 1;
    localparam int HUE_SECTORS      = 6;
    localparam int SECTOR_W         = $clog2(HUE_SECTORS);
    localparam int SECTOR_DEG       = 60;
    localparam int HUE_K_W          = 6;
    localparam int HUE_STEP         = 8;
    localparam int FLOW_INTERVAL_MS = 60;
    localparam int RAMP_MUL         = 1092;
    localparam int QUEUE_DEPTH      = 2;
    localparam int QPTR_W           = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_FIXED   = 3'd0,
        CMD_BLINK   = 3'd1,
        CMD_RAINBOW = 3'd2,
        CMD_FLOW    = 3'd3,
        CMD_TICK    = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_BLINK = 2'd1,
        MODE_FLOW  = 2'd2
    } t_mode;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [7:0]  red_in;
        logic [7:0]  green_in;
        logic [7:0]  blue_in;
        logic [15:0] period_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0] led_index;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       last;
    } t_out_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    typedef struct packed {
        logic                rainbow;
        logic [SECTOR_W-1:0] sector;
        logic [HUE_K_W-1:0]  k;
        t_rgb                color;
    } t_run;

    // round(k*65535/60) >> 8 with ties up, k in 0..60
    function automatic logic [7:0] f_ramp(input logic [HUE_K_W-1:0] k);
        logic [HUE_K_W-1:0] kp;
        logic [16:0]        v;
        kp = k + HUE_K_W'(2);
        v  = 17'(k) * 17'(RAMP_MUL) + 17'(kp[HUE_K_W-1:2]);
        return v[15:8];
    endfunction

    function automatic t_rgb f_hue_rgb(input logic [SECTOR_W-1:0] sector,
                                       input logic [HUE_K_W-1:0] k);
        logic [7:0] rise;
        logic [7:0] fall;
        t_rgb       c;
        rise = f_ramp(k);
        fall = f_ramp(HUE_K_W'(SECTOR_DEG) - k);
        case (sector)
            SECTOR_W'(0): c = '{red: 8'hFF, green: rise,  blue: 8'h00};
            SECTOR_W'(1): c = '{red: fall,  green: 8'hFF, blue: 8'h00};
            SECTOR_W'(2): c = '{red: 8'h00, green: 8'hFF, blue: rise};
            SECTOR_W'(3): c = '{red: 8'h00, green: fall,  blue: 8'hFF};
            SECTOR_W'(4): c = '{red: rise,  green: 8'h00, blue: 8'hFF};
            default:      c = '{red: 8'hFF, green: 8'h00, blue: fall};
        endcase
        return c;
    endfunction

endpackage

[rtl/core/rlee_front.sv]
// ----------------------------------------------------------------------------
// rlee_front
// Accepts commands, runs the effect timer and posts refresh runs.
// ----------------------------------------------------------------------------
module rlee_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  rlee_pkg::t_in_item i_item,
    input  logic              i_full,
    output logic              o_push,
    output rlee_pkg::t_run    o_run
);
    import rlee_pkg::*;

    t_mode               r_mode,      n_mode;
    t_rgb                r_color,     n_color;
    logic                r_blink_on,  n_blink_on;
    logic [SECTOR_W-1:0] r_sector,    n_sector;
    logic [HUE_K_W-1:0]  r_k,         n_k;
    logic [15:0]         r_interval,  n_interval;
    logic [15:0]         r_elapsed,   n_elapsed;

    logic                accept;
    logic [15:0]         elapsed_inc;
    logic [HUE_K_W:0]    k_step;
    t_rgb                in_color;

    assign o_ready     = !i_full;
    assign accept      = i_valid && o_ready;
    assign elapsed_inc = r_elapsed + 16'd1;
    assign k_step      = {1'b0, r_k} + (HUE_K_W + 1)'(HUE_STEP);
    assign in_color    = '{red: i_item.red_in, green: i_item.green_in, blue: i_item.blue_in};

    always_comb begin
        n_mode     = r_mode;
        n_color    = r_color;
        n_blink_on = r_blink_on;
        n_sector   = r_sector;
        n_k        = r_k;
        n_interval = r_interval;
        n_elapsed  = r_elapsed;
        o_push     = 1'b0;
        o_run      = '{rainbow: 1'b0, sector: '0, k: '0, color: '0};
        if (accept) begin
            case (t_cmd'(i_item.cmd))
                CMD_FIXED: begin
                    n_mode      = MODE_NONE;
                    o_push      = 1'b1;
                    o_run.color = in_color;
                end
                CMD_BLINK: begin
                    n_mode     = MODE_BLINK;
                    n_color    = in_color;
                    n_blink_on = 1'b0;
                    n_interval = (i_item.period_ms == '0) ? 16'd1 : i_item.period_ms;
                    n_elapsed  = '0;
                    o_push     = 1'b1;
                end
                CMD_RAINBOW: begin
                    n_mode        = MODE_NONE;
                    o_push        = 1'b1;
                    o_run.rainbow = 1'b1;
                end
                CMD_FLOW: begin
                    n_mode        = MODE_FLOW;
                    n_sector      = '0;
                    n_k           = '0;
                    n_interval    = 16'(FLOW_INTERVAL_MS);
                    n_elapsed     = '0;
                    o_push        = 1'b1;
                    o_run.rainbow = 1'b1;
                end
                CMD_TICK: begin
                    if (r_mode == MODE_BLINK || r_mode == MODE_FLOW) begin
                        if (elapsed_inc < r_interval) begin
                            n_elapsed = elapsed_inc;
                        end else begin
                            n_elapsed = '0;
                            o_push    = 1'b1;
                            if (r_mode == MODE_BLINK) begin
                                n_blink_on  = !r_blink_on;
                                o_run.color = r_blink_on ? t_rgb'('0) : r_color;
                            end else begin
                                if (k_step >= (HUE_K_W + 1)'(SECTOR_DEG)) begin
                                    n_k      = HUE_K_W'(k_step - (HUE_K_W + 1)'(SECTOR_DEG));
                                    n_sector = (r_sector == SECTOR_W'(HUE_SECTORS - 1)) ?
                                               '0 : r_sector + SECTOR_W'(1);
                                end else begin
                                    n_k = k_step[HUE_K_W-1:0];
                                end
                                o_run.rainbow = 1'b1;
                                o_run.sector  = n_sector;
                                o_run.k       = n_k;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_NONE;
            r_color    <= '0;
            r_blink_on <= 1'b0;
            r_sector   <= '0;
            r_k        <= '0;
            r_interval <= '0;
            r_elapsed  <= '0;
        end else begin
            r_mode     <= n_mode;
            r_color    <= n_color;
            r_blink_on <= n_blink_on;
            r_sector   <= n_sector;
            r_k        <= n_k;
            r_interval <= n_interval;
            r_elapsed  <= n_elapsed;
        end
    end

endmodule

[rtl/core/rlee_queue.sv]
// ----------------------------------------------------------------------------
// rlee_queue
// Short queue of refresh runs between the front and the back.
// ----------------------------------------------------------------------------
module rlee_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  rlee_pkg::t_run i_run,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output rlee_pkg::t_run o_run
);
    import rlee_pkg::*;

    t_run              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [QCNT_W-1:0] r_count,  n_count;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_run   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + QPTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + QPTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_run;
        end
    end

endmodule

[rtl/core/rlee_back.sv]
// ----------------------------------------------------------------------------
// rlee_back
// Expands one refresh run into six registered LED writes.
// ----------------------------------------------------------------------------
`include "rgb_led_effect_engine_unit_assert.svh"

module rlee_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  rlee_pkg::t_run      i_q_run,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output rlee_pkg::t_out_item o_item
);
    import rlee_pkg::*;

    logic                 r_busy;
    logic [LED_IDX_W-1:0] r_idx;
    logic                 r_rainbow;
    logic [SECTOR_W-1:0]  r_sector;
    logic [HUE_K_W-1:0]   r_k;
    t_rgb                 r_color;
    logic                 r_out_valid;
    t_out_item            r_out;

    logic                 advance;
    logic                 at_last;
    logic                 load;
    t_rgb                 led_rgb;
    t_out_item            n_out;

    assign at_last = (r_idx == LED_IDX_W'(LAST_LED));
    assign advance = r_busy && (!r_out_valid || i_ready);
    assign load    = i_q_valid && (!r_busy || (advance && at_last));
    assign o_pop   = load;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

    always_comb begin
        led_rgb = r_rainbow ? f_hue_rgb(r_sector, r_k) : r_color;
        n_out   = '{led_index: 3'(r_idx), red_out: led_rgb.red, green_out: led_rgb.green,
                    blue_out: led_rgb.blue, last: at_last};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_busy <= 1'b1;
            end else if (advance && at_last) begin
                r_busy <= 1'b0;
            end
            if (advance) begin
                r_idx <= at_last ? '0 : r_idx + LED_IDX_W'(1);
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rainbow <= i_q_run.rainbow;
            r_sector  <= i_q_run.sector;
            r_k       <= i_q_run.k;
            r_color   <= i_q_run.color;
        end else if (advance) begin
            r_sector <= (r_sector == SECTOR_W'(HUE_SECTORS - 1)) ? '0 : r_sector + SECTOR_W'(1);
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    `RLEE_ASSERT_IMP(a_last_on_final, i_clk, i_rst_n, r_out_valid, r_out.last == (r_out.led_index == 3'(LAST_LED)), "last flag out of step with led index")
    `RLEE_ASSERT_IMP(a_idle_idx_zero, i_clk, i_rst_n, !r_busy, r_idx == '0, "idle back end with nonzero led index")
    `RLEE_ASSERT_IMP(a_pop_nonempty, i_clk, i_rst_n, o_pop, i_q_valid, "pop from empty queue")
    `RLEE_ASSERT_NXT(a_run_continues, i_clk, i_rst_n, advance && !at_last, r_busy, "run dropped before sixth write")

endmodule

[rtl/core/rgb_led_effect_engine_unit.sv]
// ----------------------------------------------------------------------------
// rgb_led_effect_engine_unit
// Effect engine for six RGB LEDs: fixed, blink, rainbow and rainbow flow.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready, i_item): one command or a 1 ms tick per item.
// Output channel (o_valid/i_ready, o_item): LED writes, index 0 to 5, with
// last set on the sixth write of each refresh run.
// Fixed, blink, rainbow and rainbow flow always cause a run; a tick causes one
// only when the running effect's timer expires; other codes cause nothing.
// The front takes one item per cycle while the two-entry run queue has room.
// The back emits one LED write per cycle while the receiver is ready; a queued
// run's first write directly follows the previous run's last write. A run's
// first write passes the queue, the back's run register and output register.
// When the receiver stalls, the output register holds its write, the back
// stops, the queue fills and o_ready drops; nothing is lost.
// Reset clears the effect (no timer running), the queue and the output.
// ----------------------------------------------------------------------------
module rgb_led_effect_engine_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  rlee_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output rlee_pkg::t_out_item o_item
);
    import rlee_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic q_valid;
    t_run push_run;
    t_run head_run;

    rlee_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_item  (i_item),
        .i_full  (full),
        .o_push  (push),
        .o_run   (push_run)
    );

    rlee_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (push_run),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_run   (head_run)
    );

    rlee_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_run   (head_run),
        .o_pop     (pop),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_item    (o_item)
    );

endmodule
